// ===== rtl/core/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg: stopwatch digit types and constants
// Item types for both channels, internal stage types, reciprocal constants
// for the divisions by constants and the decimal digit split.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

  // input item: one display tick
  typedef struct packed {
    logic [31:0] now_ms;
    logic        reset_click;
    logic        short_press;
  } swd_in_t;

  // result item: six digits, change mask and run flag
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [3:0] centi_tens;
    logic [3:0] centi_units;
    logic [5:0] changed_mask;
    logic       is_running;
  } swd_out_t;

  // shown time in milliseconds, leaving the state update
  typedef struct packed {
    logic [31:0] shown_ms;
    logic        running;
  } swd_ms_t;

  // time split into fields, leaving the conversion pipeline
  typedef struct packed {
    logic [6:0] centi;     // centiseconds, 0..99
    logic [5:0] secs;      // seconds, 0..59
    logic [6:0] min_lo;    // total minutes, low bits
    logic [9:0] min_hund;  // total minutes / 100
    logic       running;
  } swd_split_t;

  localparam int NUM_DIGITS = 6;

  // digit positions in the change mask
  localparam int DIG_MIN_TENS    = 0;
  localparam int DIG_MIN_UNITS   = 1;
  localparam int DIG_SEC_TENS    = 2;
  localparam int DIG_SEC_UNITS   = 3;
  localparam int DIG_CENTI_TENS  = 4;
  localparam int DIG_CENTI_UNITS = 5;

  // reciprocals: floor(x/d) = (x * RECIP) >> SHIFT, exact for 32-bit x
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          SHIFT_10   = 35;
  localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
  localparam int          SHIFT_100  = 37;
  localparam logic [31:0] RECIP_60   = 32'h8888_8889;
  localparam int          SHIFT_60   = 37;

  localparam logic [6:0]  CS_PER_SEC  = 7'd100;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [6:0]  MIN_WRAP    = 7'd100;

  // tens digit of a value 0..99 by threshold compares
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) t = 4'(k);
    end
    return t;
  endfunction

  // units digit of a value 0..99
  function automatic logic [3:0] units_of(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] ten_x;
    t     = tens_of(v);
    ten_x = 7'({t, 3'b000}) + 7'({t, 1'b0});
    return 4'(v - ten_x);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/swd_state.sv =====
// ----------------------------------------------------------------------------
// swd_state: run flag, accumulated time and segment start
// Applies reset click then press on each accepted item and forms the
// shown time in milliseconds for the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_state (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire swd_pkg::swd_in_t item,
  output swd_pkg::swd_ms_t      ms_item,
  output logic                  run_now
);

  logic        run_r, run_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] seg_r, seg_nxt;

  logic        run_a;
  logic [31:0] acc_a;
  logic [31:0] elapsed;
  logic [31:0] shown;

  // reset click first, then the press
  always_comb begin
    run_a   = item.reset_click ? 1'b0 : run_r;
    acc_a   = item.reset_click ? 32'd0 : acc_r;
    elapsed = item.now_ms - seg_r;
    shown   = acc_a + (run_a ? elapsed : 32'd0);

    run_nxt = item.short_press ? ~run_a : run_a;
    acc_nxt = (run_a && item.short_press) ? shown : acc_a;
    seg_nxt = (!run_a && item.short_press) ? item.now_ms : seg_r;

    ms_item.shown_ms = shown;
    ms_item.running  = run_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      acc_r <= 32'd0;
      seg_r <= 32'd0;
    end else if (accept) begin
      run_r <= run_nxt;
      acc_r <= acc_nxt;
      seg_r <= seg_nxt;
    end
  end

  assign run_now = run_r;

endmodule

`default_nettype wire

// ===== rtl/core/swd_conv.sv =====
// ----------------------------------------------------------------------------
// swd_conv: millisecond to minutes, seconds and centiseconds
// Five stage pipeline of reciprocal multiplies with per-stage valid bits;
// a stage moves on when the next one is empty or moving.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_conv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire swd_pkg::swd_ms_t  up_item,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output swd_pkg::swd_split_t    dn_item
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage payloads
  logic [31:0] ms1_r;
  logic        run1_r, run2_r, run3_r, run4_r, run5_r;
  logic [28:0] tcs2_r;
  logic [6:0]  tcs3_r;
  logic [22:0] sec3_r;
  logic [6:0]  cs4_r, cs5_r;
  logic [5:0]  sec4_r, ss5_r;
  logic [16:0] min4_r;
  logic [6:0]  min5_r;
  logic [9:0]  mq5_r;

  logic [63:0] p_tcs, p_sec, p_min, p_mq;
  logic [13:0] sec_x100;
  logic [11:0] min_x60;

  // stage advance chain
  assign adv5     = !v5_r || dn_ready;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // reciprocal products and remainder terms
  always_comb begin
    p_tcs    = {32'd0, ms1_r} * {32'd0, swd_pkg::RECIP_10};
    p_sec    = {35'd0, tcs2_r} * {32'd0, swd_pkg::RECIP_100};
    p_min    = {41'd0, sec3_r} * {32'd0, swd_pkg::RECIP_60};
    p_mq     = {47'd0, min4_r} * {32'd0, swd_pkg::RECIP_100};
    sec_x100 = {7'd0, sec3_r[6:0]} * {7'd0, swd_pkg::CS_PER_SEC};
    min_x60  = {6'd0, min4_r[5:0]} * {6'd0, swd_pkg::SEC_PER_MIN};
  end

  // stage 1: shown milliseconds
  always_ff @(posedge clk) begin
    if (adv1) begin
      ms1_r  <= up_item.shown_ms;
      run1_r <= up_item.running;
    end
  end

  // stage 2: total centiseconds
  always_ff @(posedge clk) begin
    if (adv2) begin
      tcs2_r <= p_tcs[swd_pkg::SHIFT_10 +: 29];
      run2_r <= run1_r;
    end
  end

  // stage 3: total seconds
  always_ff @(posedge clk) begin
    if (adv3) begin
      tcs3_r <= tcs2_r[6:0];
      sec3_r <= p_sec[swd_pkg::SHIFT_100 +: 23];
      run3_r <= run2_r;
    end
  end

  // stage 4: centiseconds, total minutes
  always_ff @(posedge clk) begin
    if (adv4) begin
      cs4_r  <= tcs3_r - sec_x100[6:0];
      sec4_r <= sec3_r[5:0];
      min4_r <= p_min[swd_pkg::SHIFT_60 +: 17];
      run4_r <= run3_r;
    end
  end

  // stage 5: seconds, hundreds of minutes
  always_ff @(posedge clk) begin
    if (adv5) begin
      cs5_r  <= cs4_r;
      ss5_r  <= sec4_r - min_x60[5:0];
      min5_r <= min4_r[6:0];
      mq5_r  <= p_mq[swd_pkg::SHIFT_100 +: 10];
      run5_r <= run4_r;
    end
  end

  assign dn_valid         = v5_r;
  assign dn_item.centi    = cs5_r;
  assign dn_item.secs     = ss5_r;
  assign dn_item.min_lo   = min5_r;
  assign dn_item.min_hund = mq5_r;
  assign dn_item.running  = run5_r;

endmodule

`default_nettype wire

// ===== rtl/core/swd_mask.sv =====
// ----------------------------------------------------------------------------
// swd_mask: digit split, change mask and result register
// Wraps minutes at 100, splits each field into two digits, compares them
// with the last shown digits and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_mask (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire swd_pkg::swd_split_t up_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output swd_pkg::swd_out_t        out_data
);

  logic              out_valid_r;
  swd_pkg::swd_out_t out_r, out_nxt;
  logic [3:0]        shown_r [swd_pkg::NUM_DIGITS];
  logic [3:0]        dig     [swd_pkg::NUM_DIGITS];
  logic [13:0]       hund_x;
  logic [6:0]        mm;
  logic [5:0]        mask;
  logic              load;

  assign up_ready = !out_valid_r || out_ready;
  assign load     = up_valid && up_ready;

  // minutes modulo 100 and digit split
  always_comb begin
    hund_x = {7'd0, up_item.min_hund[6:0]} * {7'd0, swd_pkg::MIN_WRAP};
    mm     = up_item.min_lo - hund_x[6:0];

    dig[swd_pkg::DIG_MIN_TENS]    = swd_pkg::tens_of(mm);
    dig[swd_pkg::DIG_MIN_UNITS]   = swd_pkg::units_of(mm);
    dig[swd_pkg::DIG_SEC_TENS]    = swd_pkg::tens_of({1'b0, up_item.secs});
    dig[swd_pkg::DIG_SEC_UNITS]   = swd_pkg::units_of({1'b0, up_item.secs});
    dig[swd_pkg::DIG_CENTI_TENS]  = swd_pkg::tens_of(up_item.centi);
    dig[swd_pkg::DIG_CENTI_UNITS] = swd_pkg::units_of(up_item.centi);

    for (int i = 0; i < swd_pkg::NUM_DIGITS; i++) begin
      mask[i] = (dig[i] != shown_r[i]);
    end

    out_nxt.min_tens     = dig[swd_pkg::DIG_MIN_TENS];
    out_nxt.min_units    = dig[swd_pkg::DIG_MIN_UNITS];
    out_nxt.sec_tens     = dig[swd_pkg::DIG_SEC_TENS][2:0];
    out_nxt.sec_units    = dig[swd_pkg::DIG_SEC_UNITS];
    out_nxt.centi_tens   = dig[swd_pkg::DIG_CENTI_TENS];
    out_nxt.centi_units  = dig[swd_pkg::DIG_CENTI_UNITS];
    out_nxt.changed_mask = mask;
    out_nxt.is_running   = up_item.running;
  end

  // result valid and last shown digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < swd_pkg::NUM_DIGITS; i++) begin
        shown_r[i] <= 4'd0;
      end
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < swd_pkg::NUM_DIGITS; i++) begin
          shown_r[i] <= dig[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/stopwatch_mmsscc_digits.sv =====
// ----------------------------------------------------------------------------
// stopwatch_mmsscc_digits: start/stop/reset stopwatch shown as MM:SS:CC
// Keeps the running time from display ticks and gives six decimal digits
// with a mask of the digits that changed since the previous result.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one tick: the millisecond clock, a reset
//   click and a start/stop press. Each accepted item gives exactly one result
//   item on out_valid/out_ready/out_data, in order.
//   The run flag, accumulated time and segment start are updated in the
//   cycle the item is accepted; the shown time then passes a five stage
//   conversion pipeline (divide by 10, 100, 60 and minutes modulo 100 by
//   reciprocal multiplies) into the result register.
//   Throughput: one item per cycle while the receiver keeps taking results.
//   A stalled receiver holds the result; items keep entering until every
//   pipeline stage is full, then in_ready drops.
//   Reset (rst_n low, synchronous) stops the watch, clears the time and the
//   last shown digits to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_mmsscc_digits (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swd_pkg::swd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swd_pkg::swd_out_t      out_data
);

  logic                accept;
  logic                run_now;
  swd_pkg::swd_ms_t    ms_item;
  logic                split_valid;
  logic                split_ready;
  swd_pkg::swd_split_t split_item;

  assign accept = in_valid && in_ready;

  // state update on each accepted item
  swd_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_data),
    .ms_item (ms_item),
    .run_now (run_now)
  );

  // time conversion pipeline
  swd_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (ms_item),
    .dn_valid (split_valid),
    .dn_ready (split_ready),
    .dn_item  (split_item)
  );

  // digits, change mask and result register
  swd_mask u_mask (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (split_valid),
    .up_ready  (split_ready),
    .up_item   (split_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // a reset click alone leaves the watch stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.reset_click && !in_data.short_press |=> !run_now)
    else $error("watch running after reset click");

  // a press without reset toggles the run flag
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_data.reset_click && in_data.short_press |=>
      run_now != $past(run_now))
    else $error("press did not toggle run flag");

  // the input only stalls when the result is held by the receiver
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with pipeline free");

  // digits stay decimal
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.min_tens <= 4'd9 && out_data.min_units <= 4'd9 &&
      out_data.sec_tens <= 3'd5 && out_data.sec_units <= 4'd9 &&
      out_data.centi_tens <= 4'd9 && out_data.centi_units <= 4'd9)
    else $error("digit out of range");
`endif

endmodule

`default_nettype wire
